// ===== design/mlfb_pkg.sv =====
// shared types and constants for the memory lcd frame buffer writer
`timescale 1ns / 1ps
`default_nettype none

package mlfb_pkg;

    // byte position counter and column-within-line counter widths
    localparam int POS_W = 13;
    localparam int COL_W = 5;
    localparam int CNT_W = $clog2(POS_W);

    // register indexes
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_ROTATION = 2'd2;

    // item kinds
    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_REFRESH = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic [7:0] BIT_OF [8] = '{8'd1, 8'd2, 8'd4, 8'd8,
                                          8'd16, 8'd32, 8'd64, 8'd128};

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_CMD        = 7'b0000010,
        PH_FIRST_ADDR = 7'b0000100,
        PH_DATA       = 7'b0001000,
        PH_EOL        = 7'b0010000,
        PH_ADDR       = 7'b0100000,
        PH_TRAILER    = 7'b1000000
    } phase_t;

    typedef enum logic [3:0] {
        ST_CLEAR   = 4'b0001,
        ST_READY   = 4'b0010,
        ST_PIX_WR  = 4'b0100,
        ST_TICK_RD = 4'b1000
    } ctl_t;

    // status of the serial remainder unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [COL_W-1:0] rem;
    } mod_status_t;

endpackage

`default_nettype wire

// ===== design/mlfb_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mlfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/mlfb_mod_unit.sv =====
// serial remainder unit: byte position modulo bytes per line, one bit a cycle
`timescale 1ns / 1ps
`default_nettype none

module mlfb_mod_unit
    import mlfb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [POS_W-1:0] dividend,
    input  wire logic [COL_W-1:0] divisor,
    output mod_status_t           status
);

    logic             run_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0] dvd_reg;
    logic [COL_W-1:0] div_reg;
    logic [COL_W-1:0] rem_reg;
    logic [COL_W:0]   trial;
    logic [COL_W:0]   rem_step;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[POS_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_step = trial - {1'b0, div_reg};
        end
        else
        begin
            rem_step = trial;
        end
    end

    assign status.busy = run_reg;
    assign status.done = run_reg && (cnt_reg == '0);
    assign status.rem  = rem_step[COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= CNT_W'(POS_W - 1);
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[POS_W-2:0], 1'b0};
            rem_reg <= rem_step[COL_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/memory_lcd_frame_buffer_writer_core.sv =====
// top level of the memory lcd frame buffer writer
`timescale 1ns / 1ps
`default_nettype none

// channel     direction  handshake                     payload
// s_axis      in         s_axis_tvalid/s_axis_tready   tdata {pixel_on,pixel_y,pixel_x}, tuser kind
// m_axis      out        m_axis_tvalid/m_axis_tready   tdata serial_byte, tuser, tlast frame_end
// apb         in         psel/penable, pready high     panel_width, panel_height, rotation
//
// a refresh, a tick outside the data lines, an unused kind and a dropped pixel are handled without leaving ST_READY
// a pixel write reads in ST_READY, then writes back in ST_PIX_WR (through the single ram port pair)
// a data tick reads the ram, then in ST_TICK_RD its byte lands in the output register
// after reset a clearing pass writes zero to all BUFFER_BYTES entries, one per cycle,
// and no transaction is taken on s_axis meanwhile (config writes still land)
// a panel_width write stalls s_axis for its access cycle and the whole column rebuild

module memory_lcd_frame_buffer_writer_core
    import mlfb_pkg::*;
#(
    parameter int BUFFER_BYTES  = 8192,
    parameter int WRITE_COMMAND = 128,
    parameter int VCOM_MASK     = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [16] pixel_on
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] serial_byte
    output logic [1:0]       m_axis_tuser,   // [0] msb_first, [1] frame_start
    output logic             m_axis_tlast,   // frame_end
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [POS_W:0] BUF_LIMIT = (POS_W + 1)'(BUFFER_BYTES);

    // configuration registers
    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic [1:0] rot_reg;

    // stream state
    ctl_t             ctl_reg;
    phase_t           phase_reg;
    logic             vcom_reg;
    logic             active_reg;
    logic [POS_W-1:0] bp_reg;
    logic [COL_W-1:0] col_reg;
    logic [7:0]       line_reg;
    logic [AW-1:0]    clr_reg;

    // pending pixel write
    logic [AW-1:0] pend_addr_reg;
    logic [7:0]    pend_mask_reg;
    logic          pend_on_reg;
    logic          oob_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_msb_reg;
    logic       out_fs_reg;
    logic       out_fe_reg;

    logic        cfg_wr;
    logic        width_wr;
    logic        accept;
    logic [1:0]  kind;
    logic [7:0]  px;
    logic [7:0]  py;
    logic        pon;
    logic        tick_live;

    logic [COL_W-1:0] lb;
    logic [POS_W-1:0] total;

    // pixel address path
    logic [8:0]       rx;
    logic [8:0]       ry;
    logic             pix_in;
    logic [15:0]      lin;
    logic [POS_W-1:0] idx;
    logic             pix_ok;

    // data tick path
    logic [POS_W-1:0] bp_inc;
    logic [COL_W-1:0] col_inc;

    // non-data tick result
    logic [7:0] tick_byte;
    logic       tick_msb;
    logic       tick_fs;
    logic       tick_fe;
    logic       load_direct;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    mod_status_t mod_st;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign width_wr = cfg_wr && (paddr[3:2] == REG_WIDTH);

    assign kind = s_axis_tuser;
    assign px   = s_axis_tdata[7:0];
    assign py   = s_axis_tdata[15:8];
    assign pon  = s_axis_tdata[16];

    // one transaction at a time; the output slot must be free or draining
    assign s_axis_tready = (ctl_reg == ST_READY) && !mod_st.busy && !width_wr
                           && (!out_valid_reg || m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign tick_live = accept && (kind == KIND_TICK) && active_reg && (phase_reg != PH_IDLE);

    // bytes per line, at least one, and the frame's data size
    assign lb    = (width_reg[7:3] == '0) ? COL_W'(1) : width_reg[7:3];
    assign total = POS_W'({8'd0, lb} * {5'd0, height_reg});

    // rotation into 9-bit two's complement, bit 8 flags a negative result
    always_comb
    begin
        case (rot_reg)
            ROT_90:
            begin
                rx = {1'b0, width_reg} - 9'd1 - {1'b0, py};
                ry = {1'b0, px};
            end
            ROT_180:
            begin
                rx = {1'b0, width_reg} - 9'd1 - {1'b0, px};
                ry = {1'b0, height_reg} - 9'd1 - {1'b0, py};
            end
            ROT_270:
            begin
                rx = {1'b0, py};
                ry = {1'b0, height_reg} - 9'd1 - {1'b0, px};
            end
            default:
            begin
                rx = {1'b0, px};
                ry = {1'b0, py};
            end
        endcase
    end

    assign pix_in = (px < width_reg) && (py < height_reg) && !rx[8] && !ry[8]
                    && (rx[7:0] < width_reg) && (ry[7:0] < height_reg);
    assign lin    = ({8'd0, ry[7:0]} * {8'd0, width_reg}) + {8'd0, rx[7:0]};
    assign idx    = lin[15:3];
    assign pix_ok = pix_in && ({1'b0, idx} < BUF_LIMIT);

    // next data position and its column; a wrap of the position starts a line
    assign bp_inc = bp_reg + 1'b1;
    always_comb
    begin
        if (bp_inc == '0)
        begin
            col_inc = '0;
        end
        else if ((col_reg + 1'b1) == lb)
        begin
            col_inc = '0;
        end
        else
        begin
            col_inc = col_reg + 1'b1;
        end
    end

    // bytes that come straight from the counters
    always_comb
    begin
        tick_byte = BYTE_ZERO;
        tick_msb  = 1'b0;
        tick_fs   = 1'b0;
        tick_fe   = 1'b0;
        case (phase_reg)
            PH_CMD:
            begin
                tick_byte = 8'(WRITE_COMMAND) | (vcom_reg ? 8'(VCOM_MASK) : BYTE_ZERO);
                tick_msb  = 1'b1;
                tick_fs   = 1'b1;
            end
            PH_FIRST_ADDR: tick_byte = 8'd1;
            PH_ADDR:       tick_byte = line_reg;
            PH_TRAILER:    tick_fe   = 1'b1;
            default:       tick_byte = BYTE_ZERO;
        endcase
    end

    assign load_direct = tick_live && (phase_reg != PH_DATA);

    // ram access: clearing pass, pixel write-back, pixel or data reads
    assign ram_we    = (ctl_reg == ST_CLEAR) || (ctl_reg == ST_PIX_WR);
    assign ram_waddr = (ctl_reg == ST_CLEAR) ? clr_reg : pend_addr_reg;
    assign ram_wdata = (ctl_reg == ST_CLEAR) ? BYTE_ZERO
                     : (pend_on_reg ? (ram_rdata | pend_mask_reg)
                                    : (ram_rdata & ~pend_mask_reg));
    assign ram_raddr = (kind == KIND_PIXEL) ? idx[AW-1:0] : bp_reg[AW-1:0];

    mlfb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_pixel_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // rebuilds col_reg = bp_reg % lb after a width change
    mlfb_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (width_wr),
        .dividend (bp_reg),
        .divisor  ((pwdata[7:3] == '0) ? COL_W'(1) : pwdata[7:3]),
        .status   (mod_st)
    );

    // configuration registers and read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            rot_reg    <= ROT_0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WIDTH:    width_reg  <= pwdata[7:0];
                REG_HEIGHT:   height_reg <= pwdata[7:0];
                REG_ROTATION: rot_reg    <= pwdata[1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:    prdata = {24'd0, width_reg};
            REG_HEIGHT:   prdata = {24'd0, height_reg};
            REG_ROTATION: prdata = {30'd0, rot_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= ST_CLEAR;
            clr_reg <= '0;
        end
        else
        begin
            case (ctl_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(BUFFER_BYTES - 1))
                    begin
                        ctl_reg <= ST_READY;
                    end
                end
                ST_READY:
                begin
                    if (accept && (kind == KIND_PIXEL) && pix_ok)
                    begin
                        ctl_reg <= ST_PIX_WR;
                    end
                    else if (tick_live && (phase_reg == PH_DATA))
                    begin
                        ctl_reg <= ST_TICK_RD;
                    end
                end
                ST_PIX_WR:  ctl_reg <= ST_READY;
                ST_TICK_RD: ctl_reg <= ST_READY;
                default:    ctl_reg <= ST_READY;
            endcase
        end
    end

    // pending write and out-of-buffer flag, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_addr_reg <= idx[AW-1:0];
            pend_mask_reg <= BIT_OF[rx[2:0]];
            pend_on_reg   <= pon;
            oob_reg       <= {1'b0, bp_reg} >= BUF_LIMIT;
        end
    end

    // frame stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            vcom_reg   <= 1'b0;
            active_reg <= 1'b0;
            bp_reg     <= '0;
            col_reg    <= '0;
            line_reg   <= 8'd1;
        end
        else if (mod_st.done)
        begin
            col_reg <= mod_st.rem;
        end
        else if (accept && (kind == KIND_REFRESH))
        begin
            active_reg <= 1'b1;
            phase_reg  <= PH_CMD;
            bp_reg     <= '0;
            col_reg    <= '0;
            line_reg   <= 8'd1;
        end
        else if (tick_live)
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    vcom_reg  <= !vcom_reg;
                    phase_reg <= PH_FIRST_ADDR;
                end
                PH_FIRST_ADDR:
                begin
                    line_reg  <= 8'd1;
                    phase_reg <= (bp_reg < total) ? PH_DATA : PH_TRAILER;
                end
                PH_DATA:
                begin
                    bp_reg  <= bp_inc;
                    col_reg <= col_inc;
                    if ((col_inc == '0) || (bp_inc >= total))
                    begin
                        phase_reg <= PH_EOL;
                    end
                end
                PH_EOL:
                begin
                    line_reg  <= line_reg + 1'b1;
                    phase_reg <= (bp_reg < total) ? PH_ADDR : PH_TRAILER;
                end
                PH_ADDR: phase_reg <= PH_DATA;
                default:
                begin
                    active_reg <= 1'b0;
                    phase_reg  <= PH_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_direct || (ctl_reg == ST_TICK_RD))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_direct)
        begin
            out_byte_reg <= tick_byte;
            out_msb_reg  <= tick_msb;
            out_fs_reg   <= tick_fs;
            out_fe_reg   <= tick_fe;
        end
        else if (ctl_reg == ST_TICK_RD)
        begin
            out_byte_reg <= oob_reg ? BYTE_ZERO : ram_rdata;
            out_msb_reg  <= 1'b0;
            out_fs_reg   <= 1'b0;
            out_fe_reg   <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_fs_reg, out_msb_reg};
    assign m_axis_tlast  = out_fe_reg;

    // no transaction taken while the buffer is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    // a data read never finds the output slot occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == ST_TICK_RD) |-> !out_valid_reg)
        else $error("data byte would overwrite a waiting byte");

    // column counter tracks position modulo bytes per line once rebuilt
    assert property (@(posedge clk) disable iff (!rst_n)
        !mod_st.busy |-> (col_reg < lb))
        else $error("column counter out of range");

    // frame flag and phase agree
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == (phase_reg != PH_IDLE))
        else $error("refresh flag and phase disagree");

    // a width write holds off input until the column is rebuilt
    assert property (@(posedge clk) disable iff (!rst_n)
        width_wr |=> (mod_st.busy && !s_axis_tready))
        else $error("input taken during column rebuild");

endmodule

`default_nettype wire
